// ===== sv/bstl_pkg.sv =====
// ----------------------------------------------------------------------------
// bstl_pkg: shared types, constants and helpers of the byte stream lexer
// Token and scan-state types, character classes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package bstl_pkg;

   localparam int POS_W      = 16;                  // byte position width
   localparam int DW         = POS_W + 1;           // width for length math
   localparam int MAX_BRACES = 255;
   localparam int MAX_RES    = 3;                   // results per byte
   localparam int Q_DEPTH    = 8;
   localparam int Q_AW       = $clog2(Q_DEPTH);
   localparam int Q_CW       = $clog2(Q_DEPTH + 1);

   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam logic [15:0]      LC_MAX  = 16'hFFFF;
   localparam logic [7:0]       RUN_MAX = 8'hFF;
   localparam logic [7:0]       OPEN_MAX = 8'(MAX_BRACES);

   localparam logic [2:0] KW_DONE = 3'd5;           // "batch" fully matched
   localparam logic [2:0] KW_MISS = 3'd7;           // not the keyword

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_B      = 8'h62;

   typedef enum logic [3:0] {
      SCAN_IDLE   = 4'd0,
      SCAN_IDENT  = 4'd1,
      SCAN_NUMBER = 4'd2,
      SCAN_STRING = 4'd3,
      SCAN_ESCAPE = 4'd4,
      SCAN_WAIT   = 4'd5,
      SCAN_OPEN   = 4'd6,
      SCAN_BODY   = 4'd7,
      SCAN_HALT   = 4'd8
   } scan_type;

   typedef enum logic [4:0] {
      KIND_EOF     = 5'd0,
      KIND_IDENT   = 5'd1,
      KIND_NUMBER  = 5'd2,
      KIND_LPAREN  = 5'd3,
      KIND_RPAREN  = 5'd4,
      KIND_LBRACE  = 5'd5,
      KIND_RBRACE  = 5'd6,
      KIND_SEMI    = 5'd7,
      KIND_COMMA   = 5'd8,
      KIND_STRING  = 5'd9,
      KIND_COLON   = 5'd10,
      KIND_ASSIGN  = 5'd11,
      KIND_BANG    = 5'd12,
      KIND_STAR    = 5'd13,
      KIND_PLUS    = 5'd14,
      KIND_MINUS   = 5'd15,
      KIND_SLASH   = 5'd16,
      KIND_BODY    = 5'd17,
      KIND_UNKNOWN = 5'd18,
      KIND_ERROR   = 5'd19
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic [15:0] col;
      logic [7:0]  code;
      logic        last;
   } tok_type;

   typedef struct packed {
      scan_type         scan;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] tstart;
      logic [15:0]      line;
      logic [15:0]      col;
      logic [15:0]      tline;
      logic [15:0]      tcol;
      logic [2:0]       kp;
      logic [7:0]       open;
      logic [7:0]       close;
   } state_type;

   typedef struct packed {
      logic [1:0]                count;
      tok_type [MAX_RES-1:0]     tok;
   } push_type;

   localparam state_type STATE_RESET = '{
      scan: SCAN_IDLE, pos: '0, tstart: '0, line: 16'd1, col: '0,
      tline: 16'd1, tcol: 16'd1, kp: '0, open: '0, close: '0};

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || (b == 8'h5F);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39);
   endfunction

   // KIND_EOF means not a punctuator
   function automatic kind_type punct_kind(input logic [7:0] b);
      kind_type k;
      case (b)
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         8'h3B:   k = KIND_SEMI;
         8'h2C:   k = KIND_COMMA;
         8'h3A:   k = KIND_COLON;
         8'h3D:   k = KIND_ASSIGN;
         8'h21:   k = KIND_BANG;
         8'h2A:   k = KIND_STAR;
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h2F:   k = KIND_SLASH;
         default: k = KIND_EOF;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] kw_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h62;  // b
         3'd1:    c = 8'h61;  // a
         3'd2:    c = 8'h74;  // t
         3'd3:    c = 8'h63;  // c
         3'd4:    c = 8'h68;  // h
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // a - b, floored at zero
   function automatic logic [15:0] diff0(input logic [DW-1:0] a, input logic [DW-1:0] b);
      logic [DW-1:0] d;
      d = a - b;
      return (a > b) ? d[15:0] : 16'd0;
   endfunction

   function automatic tok_type make_tok(input kind_type k, input logic [15:0] s,
                                        input logic [15:0] l, input logic [15:0] ln,
                                        input logic [15:0] cl, input logic [7:0] ch);
      tok_type t;
      t.kind  = k;
      t.start = s;
      t.len   = l;
      t.line  = ln;
      t.col   = cl;
      t.code  = ch;
      t.last  = 1'b0;
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== sv/byte_stream_token_lexer_core.sv =====
// Path: an accepted byte is held in the input register; its tokens are then written to the queue, which drives rsp.
// Throughput: one byte per cycle while the token queue has room for three tokens;
// a byte that makes two or three tokens can hold input until the eight-entry
// queue drains, at one token per cycle while rsp_tready is high.
// Reset: synchronous; clears the input stage, the queue and the scan state
// (line 1, column 0, position 0). An end-of-input byte also restores that state.
// ----------------------------------------------------------------------------
// byte_stream_token_lexer_core: byte stream lexer, top level
// Input byte register, one-step lexer logic and a token queue.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stream_token_lexer_core import bstl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [15:0] start_offset, [31:16] text_length,
                                    // [47:32] line_number, [63:48] column_number,
                                    // [71:64] char_code
   output logic [4:0]  rsp_tuser,   // [4:0] token_kind
   output logic        rsp_tlast    // last
);

   logic            item_valid_ff;
   logic            item_valid_in;
   logic [7:0]      byte_ff;
   logic            eoi_ff;
   state_type       state_ff;
   state_type       state_in;
   push_type        step_push;
   push_type        q_push;
   tok_type         q_head;
   logic            q_valid;
   logic [Q_CW-1:0] q_level;
   logic            room;
   logic            process;
   logic            req_take;

   assign room       = (q_level <= Q_CW'(Q_DEPTH - MAX_RES));
   assign process    = item_valid_ff && room;
   assign req_tready = !item_valid_ff || process;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
      end else if (process) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         state_ff      <= STATE_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         if (process) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         byte_ff <= req_tdata;
         eoi_ff  <= req_tlast;
      end
   end

   bstl_step u_step (
      .cur  (state_ff),
      .data (byte_ff),
      .eoi  (eoi_ff),
      .nxt  (state_in),
      .push (step_push)
   );

   always_comb begin
      q_push       = step_push;
      q_push.count = process ? step_push.count : 2'd0;
   end

   bstl_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (rsp_tvalid && rsp_tready),
      .head  (q_head),
      .valid (q_valid),
      .level (q_level)
   );

   assign rsp_tvalid = q_valid;
   assign rsp_tdata  = {q_head.code, q_head.col, q_head.line, q_head.len, q_head.start};
   assign rsp_tuser  = q_head.kind;
   assign rsp_tlast  = q_head.last;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= Q_CW'(Q_DEPTH))
      else $error("token queue over capacity");

   a_eoi_emits: assert property (@(posedge clock) disable iff (reset)
      (process && eoi_ff) |-> (step_push.count != 2'd0))
      else $error("end of input gave no token");

   a_eoi_restart: assert property (@(posedge clock) disable iff (reset)
      (process && eoi_ff) |=> (state_ff.pos == '0 && state_ff.scan == SCAN_IDLE))
      else $error("scan state not restored after end of input");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.line != 16'd0)
      else $error("line count reached zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("token output valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== sv/bstl_step.sv =====
// ----------------------------------------------------------------------------
// bstl_step: one lexer step
// Takes the scan state and one byte, gives the next state and up to three
// tokens, first one in slot zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bstl_step import bstl_pkg::*; (
   input  state_type  cur,
   input  logic [7:0] data,
   input  logic       eoi,
   output state_type  nxt,
   output push_type   push
);

   state_type        w;
   logic [POS_W-1:0] npos;
   logic [15:0]      bcol;
   logic [15:0]      ecol;
   logic [7:0]       close_nx;
   logic [DW-1:0]    sstart;
   logic             run2;
   logic [3:0]       slot_v;
   tok_type [3:0]    slot_t;
   logic [1:0]       n;
   kind_type         pk;

   always_comb begin
      w        = cur;
      slot_v   = '0;
      slot_t   = '0;
      npos     = (cur.pos != POS_MAX) ? cur.pos + 1'b1 : cur.pos;
      bcol     = (cur.col != LC_MAX) ? cur.col + 16'd1 : cur.col;
      close_nx = '0;
      sstart   = '0;
      pk       = punct_kind(data);

      if (data == CH_NL) begin
         w.line = (cur.line != LC_MAX) ? cur.line + 16'd1 : cur.line;
         w.col  = '0;
      end else begin
         w.col = bcol;
      end
      w.pos = npos;

      // first pass: tokens that end on this byte hand it on to a second pass
      run2 = 1'b1;
      case (cur.scan)
         SCAN_IDENT: begin
            if (is_alpha(data) || is_digit(data)) begin
               run2 = 1'b0;
               if (cur.kp < KW_DONE && data == kw_char(cur.kp)) begin
                  w.kp = cur.kp + 3'd1;
               end else begin
                  w.kp = KW_MISS;
               end
            end else if (cur.kp == KW_DONE) begin
               w.scan = SCAN_WAIT;
            end else begin
               slot_v[0] = 1'b1;
               slot_t[0] = make_tok(KIND_IDENT, cur.tstart,
                                    diff0({1'b0, cur.pos}, {1'b0, cur.tstart}),
                                    cur.tline, cur.tcol, 8'd0);
               w.scan = SCAN_IDLE;
            end
         end
         SCAN_NUMBER: begin
            if (is_digit(data)) begin
               run2 = 1'b0;
            end else begin
               slot_v[0] = 1'b1;
               slot_t[0] = make_tok(KIND_NUMBER, cur.tstart,
                                    diff0({1'b0, cur.pos}, {1'b0, cur.tstart}),
                                    cur.tline, cur.tcol, 8'd0);
               w.scan = SCAN_IDLE;
            end
         end
         SCAN_OPEN: begin
            if (data == CH_LBRACE) begin
               run2 = 1'b0;
               if (cur.open < OPEN_MAX) begin
                  w.open = cur.open + 8'd1;
               end
            end else begin
               w.scan   = SCAN_BODY;
               w.tstart = cur.pos;
               w.tline  = cur.line;
               w.tcol   = bcol;
               w.close  = '0;
            end
         end
         default: begin
            run2 = 1'b1;
         end
      endcase

      if (run2) begin
         case (w.scan)
            SCAN_IDLE: begin
               if (is_space(data)) begin
                  w.scan = SCAN_IDLE;
               end else if (is_alpha(data)) begin
                  w.scan   = SCAN_IDENT;
                  w.tstart = cur.pos;
                  w.tline  = cur.line;
                  w.tcol   = bcol;
                  w.kp     = (data == CH_B) ? 3'd1 : KW_MISS;
               end else if (is_digit(data)) begin
                  w.scan   = SCAN_NUMBER;
                  w.tstart = cur.pos;
                  w.tline  = cur.line;
                  w.tcol   = bcol;
               end else if (data == CH_QUOTE) begin
                  w.scan   = SCAN_STRING;
                  w.tstart = npos;
                  w.tline  = cur.line;
                  w.tcol   = bcol;
               end else if (pk != KIND_EOF) begin
                  slot_v[1] = 1'b1;
                  slot_t[1] = make_tok(pk, cur.pos, 16'd1, cur.line, bcol, 8'd0);
               end else begin
                  slot_v[1] = 1'b1;
                  slot_t[1] = make_tok(KIND_UNKNOWN, cur.pos, 16'd1, cur.line, bcol, data);
               end
            end
            SCAN_STRING: begin
               if (data == CH_BSLASH) begin
                  w.scan = SCAN_ESCAPE;
               end else if (data == CH_QUOTE) begin
                  slot_v[1] = 1'b1;
                  slot_t[1] = make_tok(KIND_STRING, w.tstart,
                                       diff0({1'b0, cur.pos}, {1'b0, w.tstart}),
                                       w.tline, w.tcol, 8'd0);
                  w.scan = SCAN_IDLE;
               end
            end
            SCAN_ESCAPE: begin
               w.scan = SCAN_STRING;
            end
            SCAN_WAIT: begin
               if (is_space(data)) begin
                  w.scan = SCAN_WAIT;
               end else if (data == CH_LBRACE) begin
                  w.scan = SCAN_OPEN;
                  w.open = 8'd1;
               end else begin
                  slot_v[1] = 1'b1;
                  slot_t[1] = make_tok(KIND_ERROR, cur.pos, 16'd1, cur.line, bcol, 8'd0);
                  w.scan = SCAN_HALT;
               end
            end
            SCAN_BODY: begin
               if (data == CH_RBRACE) begin
                  close_nx = (w.close != RUN_MAX) ? w.close + 8'd1 : w.close;
                  w.close  = close_nx;
                  if (close_nx >= w.open) begin
                     slot_v[1] = 1'b1;
                     slot_t[1] = make_tok(KIND_BODY, w.tstart,
                                          diff0({1'b0, npos},
                                                {1'b0, w.tstart} + DW'(close_nx)),
                                          w.tline, w.tcol, 8'd0);
                     w.scan = SCAN_IDLE;
                  end
               end else begin
                  w.close = '0;
               end
            end
            default: begin
               w.scan = w.scan;
            end
         endcase
      end

      // end of source: flush the pending token, then eof
      ecol = (w.col != LC_MAX) ? w.col + 16'd1 : w.col;
      if (eoi) begin
         case (w.scan)
            SCAN_IDENT: begin
               slot_v[2] = 1'b1;
               if (w.kp == KW_DONE) begin
                  slot_t[2] = make_tok(KIND_ERROR, npos, 16'd0, w.line, ecol, 8'd0);
               end else begin
                  slot_t[2] = make_tok(KIND_IDENT, w.tstart,
                                       diff0({1'b0, npos}, {1'b0, w.tstart}),
                                       w.tline, w.tcol, 8'd0);
               end
            end
            SCAN_NUMBER: begin
               slot_v[2] = 1'b1;
               slot_t[2] = make_tok(KIND_NUMBER, w.tstart,
                                    diff0({1'b0, npos}, {1'b0, w.tstart}),
                                    w.tline, w.tcol, 8'd0);
            end
            SCAN_STRING, SCAN_ESCAPE: begin
               // report from the opening quote
               sstart    = DW'(diff0({1'b0, w.tstart}, DW'(1)));
               slot_v[2] = 1'b1;
               slot_t[2] = make_tok(KIND_ERROR, sstart[15:0],
                                    diff0({1'b0, npos}, sstart),
                                    w.tline, w.tcol, 8'd0);
            end
            SCAN_WAIT: begin
               slot_v[2] = 1'b1;
               slot_t[2] = make_tok(KIND_ERROR, npos, 16'd0, w.line, ecol, 8'd0);
            end
            SCAN_OPEN: begin
               slot_v[2] = 1'b1;
               slot_t[2] = make_tok(KIND_BODY, npos, 16'd0, w.line, ecol, 8'd0);
            end
            SCAN_BODY: begin
               slot_v[2] = 1'b1;
               slot_t[2] = make_tok(KIND_BODY, w.tstart,
                                    diff0({1'b0, npos}, {1'b0, w.tstart} + DW'(w.close)),
                                    w.tline, w.tcol, 8'd0);
            end
            default: begin
               slot_v[2] = 1'b0;
            end
         endcase
         slot_v[3] = 1'b1;
         slot_t[3] = make_tok(KIND_EOF, npos, 16'd0, w.line, ecol, 8'd0);
      end

      // pack the used slots in order
      n        = '0;
      push.tok = '0;
      for (int i = 0; i < 4; i++) begin
         if (slot_v[i] && n < 2'd3) begin
            push.tok[n] = slot_t[i];
            n           = n + 2'd1;
         end
      end
      if (n != 2'd0) begin
         push.tok[n - 2'd1].last = 1'b1;
      end
      push.count = n;

      nxt = eoi ? STATE_RESET : w;
   end

endmodule

`default_nettype wire

// ===== sv/bstl_queue.sv =====
// ----------------------------------------------------------------------------
// bstl_queue: token output queue
// Takes up to three tokens per cycle, gives one per cycle to the stream side while it is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bstl_queue import bstl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  push_type        push,
   input  logic            pop,
   output tok_type         head,
   output logic            valid,
   output logic [Q_CW-1:0] level
);

   tok_type [Q_DEPTH-1:0] mem_ff;
   logic [Q_AW-1:0]       head_ff;
   logic [Q_AW-1:0]       head_in;
   logic [Q_AW-1:0]       tail_ff;
   logic [Q_AW-1:0]       tail_in;
   logic [Q_CW-1:0]       level_ff;
   logic [Q_CW-1:0]       level_in;

   always_comb begin
      head_in  = head_ff + Q_AW'(pop);
      tail_in  = tail_ff + Q_AW'(push.count);
      level_in = level_ff + Q_CW'(push.count) - Q_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (2'(i) < push.count) begin
            mem_ff[tail_ff + Q_AW'(i)] <= push.tok[i];
         end
      end
   end

   assign head  = mem_ff[head_ff];
   assign valid = (level_ff != '0);
   assign level = level_ff;

endmodule

`default_nettype wire

// ===== verif/lexer_token_checker.sv =====
// ----------------------------------------------------------------------------
// lexer_token_checker: token predictor and scoreboard for the byte lexer
// Watches the byte and token channels. Each accepted byte runs through a
// behavioral lexer that queues the tokens it should produce. Each accepted
// token is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module lexer_token_checker import bstl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic [4:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LC_TOP = 65535;
   localparam int unsigned TOKENS_PER_BYTE = 3;
   localparam logic [39:0] BATCH_WORD = "batch";

   // lexer state
   scan_type         scan_st;
   logic [POS_W-1:0] cur_pos;
   logic [POS_W-1:0] tok_begin;
   logic [15:0]      cur_line;
   logic [15:0]      cur_col;
   logic [15:0]      tok_line;
   logic [15:0]      tok_col;
   logic [2:0]       kw_idx;
   logic [7:0]       open_cnt;
   logic [7:0]       close_cnt;

   tok_type expected_tokens[$];
   int      tokens_this_byte;
   int      mismatch_count = 0;
   int      token_no = 0;

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   function automatic bit is_blank(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic bit is_decimal(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   // KIND_UNKNOWN for anything outside the punctuator set
   function automatic kind_type punct_of(input logic [7:0] b);
      case (b)
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         ";":     return KIND_SEMI;
         ",":     return KIND_COMMA;
         ":":     return KIND_COLON;
         "=":     return KIND_ASSIGN;
         "!":     return KIND_BANG;
         "*":     return KIND_STAR;
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         "/":     return KIND_SLASH;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

   function automatic int unsigned floor_sub(input int unsigned a, input int unsigned b);
      return a > b ? a - b : 0;
   endfunction

   function automatic void clear_lexer();
      scan_st   = SCAN_IDLE;
      cur_pos   = '0;
      tok_begin = '0;
      cur_line  = 16'd1;
      cur_col   = 16'd0;
      tok_line  = 16'd1;
      tok_col   = 16'd1;
      kw_idx    = 3'd0;
      open_cnt  = 8'd0;
      close_cnt = 8'd0;
   endfunction

   function automatic void add_token(input kind_type k, input int unsigned s,
                                     input int unsigned l, input int unsigned ln,
                                     input int unsigned cl, input logic [7:0] ch);
      tok_type t;
      if (tokens_this_byte < TOKENS_PER_BYTE) begin
         t.kind  = k;
         t.start = s[15:0];
         t.len   = l > LC_TOP ? 16'hFFFF : l[15:0];
         t.line  = ln[15:0];
         t.col   = cl[15:0];
         t.code  = ch;
         t.last  = 1'b0;
         expected_tokens.push_back(t);
         tokens_this_byte++;
      end
   endfunction

   function automatic void lex_byte(input logic [7:0] b, input logic eoi);
      int unsigned pos, npos, bline, bcol, eline, ecol, pos_top, qstart;
      kind_type    pk;
      bit          again;
      pos_top = 32'((64'd1 << POS_W) - 1);
      tokens_this_byte = 0;
      pos   = 32'(cur_pos);
      bline = 32'(cur_line);
      bcol  = 32'(cur_col) < LC_TOP ? 32'(cur_col) + 1 : LC_TOP;
      if (b == CH_NL) begin
         if (cur_line < LC_TOP) cur_line = cur_line + 16'd1;
         cur_col = 16'd0;
      end else begin
         cur_col = bcol[15:0];
      end
      npos = pos < pos_top ? pos + 1 : pos_top;
      cur_pos = npos[POS_W-1:0];

      // an ending identifier or number, or the first body byte, hands the same byte back to the scan
      do begin
         again = 1'b0;
         case (scan_st)
            SCAN_IDLE: begin
               if (!is_blank(b)) begin
                  if (is_letter(b)) begin
                     scan_st   = SCAN_IDENT;
                     tok_begin = pos[POS_W-1:0];
                     tok_line  = bline[15:0];
                     tok_col   = bcol[15:0];
                     kw_idx    = (b == CH_B) ? 3'd1 : KW_MISS;
                  end else if (is_decimal(b)) begin
                     scan_st   = SCAN_NUMBER;
                     tok_begin = pos[POS_W-1:0];
                     tok_line  = bline[15:0];
                     tok_col   = bcol[15:0];
                  end else if (b == CH_QUOTE) begin
                     scan_st   = SCAN_STRING;
                     tok_begin = npos[POS_W-1:0];
                     tok_line  = bline[15:0];
                     tok_col   = bcol[15:0];
                  end else begin
                     pk = punct_of(b);
                     if (pk != KIND_UNKNOWN) add_token(pk, pos, 1, bline, bcol, 8'd0);
                     else add_token(KIND_UNKNOWN, pos, 1, bline, bcol, b);
                  end
               end
            end
            SCAN_IDENT: begin
               if (is_letter(b) || is_decimal(b)) begin
                  if (kw_idx < KW_DONE && b == BATCH_WORD[39 - 8 * kw_idx -: 8])
                     kw_idx = kw_idx + 3'd1;
                  else
                     kw_idx = KW_MISS;
               end else if (kw_idx == KW_DONE) begin
                  scan_st = SCAN_WAIT;
                  again   = 1'b1;
               end else begin
                  add_token(KIND_IDENT, tok_begin, floor_sub(pos, tok_begin),
                            tok_line, tok_col, 8'd0);
                  scan_st = SCAN_IDLE;
                  again   = 1'b1;
               end
            end
            SCAN_NUMBER: begin
               if (!is_decimal(b)) begin
                  add_token(KIND_NUMBER, tok_begin, floor_sub(pos, tok_begin),
                            tok_line, tok_col, 8'd0);
                  scan_st = SCAN_IDLE;
                  again   = 1'b1;
               end
            end
            SCAN_STRING: begin
               if (b == CH_BSLASH) begin
                  scan_st = SCAN_ESCAPE;
               end else if (b == CH_QUOTE) begin
                  add_token(KIND_STRING, tok_begin, floor_sub(pos, tok_begin),
                            tok_line, tok_col, 8'd0);
                  scan_st = SCAN_IDLE;
               end
            end
            SCAN_ESCAPE: scan_st = SCAN_STRING;
            SCAN_WAIT: begin
               if (!is_blank(b)) begin
                  if (b == CH_LBRACE) begin
                     scan_st  = SCAN_OPEN;
                     open_cnt = 8'd1;
                  end else begin
                     add_token(KIND_ERROR, pos, 1, bline, bcol, 8'd0);
                     scan_st = SCAN_HALT;
                  end
               end
            end
            SCAN_OPEN: begin
               if (b == CH_LBRACE) begin
                  if (open_cnt < OPEN_MAX) open_cnt = open_cnt + 8'd1;
               end else begin
                  scan_st   = SCAN_BODY;
                  tok_begin = pos[POS_W-1:0];
                  tok_line  = bline[15:0];
                  tok_col   = bcol[15:0];
                  close_cnt = 8'd0;
                  again     = 1'b1;
               end
            end
            SCAN_BODY: begin
               if (b == CH_RBRACE) begin
                  if (close_cnt < RUN_MAX) close_cnt = close_cnt + 8'd1;
                  if (close_cnt >= open_cnt) begin
                     add_token(KIND_BODY, tok_begin,
                               floor_sub(npos, 32'(tok_begin) + 32'(close_cnt)),
                               tok_line, tok_col, 8'd0);
                     scan_st = SCAN_IDLE;
                  end
               end else begin
                  close_cnt = 8'd0;
               end
            end
            default: ;
         endcase
      end while (again);

      if (eoi) begin
         eline = 32'(cur_line);
         ecol  = 32'(cur_col) < LC_TOP ? 32'(cur_col) + 1 : LC_TOP;
         case (scan_st)
            SCAN_IDENT: begin
               if (kw_idx == KW_DONE)
                  add_token(KIND_ERROR, npos, 0, eline, ecol, 8'd0);
               else
                  add_token(KIND_IDENT, tok_begin, floor_sub(npos, tok_begin),
                            tok_line, tok_col, 8'd0);
            end
            SCAN_NUMBER:
               add_token(KIND_NUMBER, tok_begin, floor_sub(npos, tok_begin),
                         tok_line, tok_col, 8'd0);
            SCAN_STRING, SCAN_ESCAPE: begin
               // report from the opening quote
               qstart = floor_sub(tok_begin, 1);
               add_token(KIND_ERROR, qstart, floor_sub(npos, qstart),
                         tok_line, tok_col, 8'd0);
            end
            SCAN_WAIT: add_token(KIND_ERROR, npos, 0, eline, ecol, 8'd0);
            SCAN_OPEN: add_token(KIND_BODY, npos, 0, eline, ecol, 8'd0);
            SCAN_BODY:
               add_token(KIND_BODY, tok_begin,
                         floor_sub(npos, 32'(tok_begin) + 32'(close_cnt)),
                         tok_line, tok_col, 8'd0);
            default: ;
         endcase
         add_token(KIND_EOF, npos, 0, eline, ecol, 8'd0);
         clear_lexer();
      end

      if (tokens_this_byte > 0)
         expected_tokens[expected_tokens.size() - 1].last = 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("[%0t] token %0d: %s", $time, token_no, msg);
   endtask

   task automatic check_token();
      tok_type want;
      token_no++;
      if (expected_tokens.size() == 0) begin
         report_mismatch($sformatf("kind %0d arrived with nothing expected", rsp_tuser));
      end else begin
         want = expected_tokens.pop_front();
         if (rsp_tuser !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", rsp_tuser, want.kind));
         if (rsp_tdata[15:0] !== want.start)
            report_mismatch($sformatf("start %0d, want %0d", rsp_tdata[15:0], want.start));
         if (rsp_tdata[31:16] !== want.len)
            report_mismatch($sformatf("length %0d, want %0d", rsp_tdata[31:16], want.len));
         if (rsp_tdata[47:32] !== want.line)
            report_mismatch($sformatf("line %0d, want %0d", rsp_tdata[47:32], want.line));
         if (rsp_tdata[63:48] !== want.col)
            report_mismatch($sformatf("column %0d, want %0d", rsp_tdata[63:48], want.col));
         if (rsp_tdata[71:64] !== want.code)
            report_mismatch($sformatf("char %0d, want %0d", rsp_tdata[71:64], want.code));
         if (rsp_tlast !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", rsp_tlast, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_lexer();
         expected_tokens.delete();
      end else begin
         if (req_tvalid && req_tready) lex_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_token();
      end
      fail_count    <= mismatch_count;
      pending_count <= expected_tokens.size();
   end

endmodule

// ===== verif/tb_byte_stream_token_lexer_core.sv =====
// ----------------------------------------------------------------------------
// tb_byte_stream_token_lexer_core: stimulus and verdict for the byte lexer
// Streams directed and random source texts with random idle cycles on both
// channels; the checker beside the core predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_byte_stream_token_lexer_core import bstl_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 280;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          pending_count;

   bit          no_idle = 1'b0;
   logic [7:0]  source_q[$];
   string       punct_chars = "(){};,:=!*+-/";
   string       blank_chars = " \t\n\v\f\r";

   always #5 clock = ~clock;

   byte_stream_token_lexer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   lexer_token_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   task automatic push_byte(input logic [7:0] b, input logic eoi);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoi;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_source();
      foreach (source_q[i]) push_byte(source_q[i], i == source_q.size() - 1);
   endtask

   // hold off the sender until every predicted token has arrived
   task automatic drain_tokens();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) source_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] word_byte(input bit tail);
      int r;
      r = tail ? $urandom_range(0, 62) : $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return "_";
      return 8'("0" + r - 53);
   endfunction

   task automatic add_fragment();
      int         sel, n;
      logic [7:0] c;
      sel = $urandom_range(0, 99);
      if (sel < 18) begin
         case ($urandom_range(0, 5))
            0, 1: push_text("batch");
            2: begin
               push_text("bat");
               repeat ($urandom_range(0, 3)) source_q.push_back(word_byte(1'b1));
            end
            default: begin
               source_q.push_back(word_byte(1'b0));
               repeat ($urandom_range(0, 5)) source_q.push_back(word_byte(1'b1));
            end
         endcase
      end else if (sel < 30) begin
         repeat ($urandom_range(1, 5)) source_q.push_back(8'("0" + $urandom_range(0, 9)));
      end else if (sel < 42) begin
         source_q.push_back(CH_QUOTE);
         repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) begin
               source_q.push_back(CH_BSLASH);
               source_q.push_back(8'($urandom_range(0, 255)));
            end else begin
               c = 8'($urandom_range(0, 255));
               if (c == CH_QUOTE || c == CH_BSLASH) c = "s";
               source_q.push_back(c);
            end
         end
         if ($urandom_range(0, 6) != 0) source_q.push_back(CH_QUOTE);
      end else if (sel < 55) begin
         source_q.push_back(punct_chars[$urandom_range(0, 12)]);
      end else if (sel < 70) begin
         repeat ($urandom_range(1, 2)) source_q.push_back(blank_chars[$urandom_range(0, 5)]);
      end else if (sel < 85) begin
         // keyword, optional blanks, N opens, raw body, usually N closes
         push_text("batch");
         repeat ($urandom_range(0, 2)) source_q.push_back(blank_chars[$urandom_range(0, 5)]);
         n = $urandom_range(1, 3);
         repeat (n) source_q.push_back(CH_LBRACE);
         repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 3) == 0) source_q.push_back(CH_RBRACE);
            else source_q.push_back(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 6) != 0) repeat (n) source_q.push_back(CH_RBRACE);
      end else begin
         repeat ($urandom_range(1, 3)) source_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : rsp_stall_gen
      int stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      int sent, round, keep;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identifier with a digit, escaped quote in a string, newline, every
      // punctuator, byte extremes as unknowns
      source_q.delete();
      push_text("x9\"\\\"\"\n(){};,:=!*+-/");
      source_q.push_back(8'h00);
      source_q.push_back(8'hFF);
      send_source();
      source_q.delete();
      push_text("batch{x}");
      send_source();

      sent  = 0;
      round = 0;
      while (sent < RANDOM_BYTES) begin
         source_q.delete();
         repeat ($urandom_range(1, 6)) add_fragment();
         // cut some sources short so end of input lands mid-token
         if ($urandom_range(0, 2) == 0) begin
            keep = $urandom_range(1, source_q.size());
            while (source_q.size() > keep) void'(source_q.pop_back());
         end
         no_idle = ($urandom_range(0, 4) == 0);
         sent += source_q.size();
         send_source();
         round++;
         if (round == 4 || round % 25 == 0) drain_tokens();
      end
      no_idle = 1'b0;

      drain_tokens();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
